### rtl/cbch_pkg.sv
`default_nettype none

package cbch_pkg;

    // Field widths
    localparam int unsigned LINE_W = 3;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned IDX_W  = 2;
    localparam int unsigned BTN_W  = 3;
    localparam int unsigned ACT_W  = 2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HOLD_THR  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HOLD_REP  = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] HOLD_THR_RST = 16'd500;
    localparam logic [CFG_W-1:0] HOLD_REP_RST = 16'd200;

    // Event kinds
    localparam logic [ACT_W-1:0] ACT_CLICK   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_HOLD    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DEBOUNCE,
        PH_PRESSED,
        PH_HOLDING
    } t_phase;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] hold_threshold;
        logic [CFG_W-1:0] hold_repeat_period;
    } t_cfg;

    typedef struct packed {
        logic             event_valid;
        logic [BTN_W-1:0] button_index;
        logic [ACT_W-1:0] action_kind;
    } t_evt;

endpackage

`default_nettype wire

### rtl/cbch_if.sv
`default_nettype none

// Sample channel
interface cbch_in_if;
    logic                            valid;
    logic                            ready;
    logic [cbch_pkg::LINE_W-1:0]     line_levels;
    logic [cbch_pkg::TIME_W-1:0]     now_ms;

    modport source (output valid, output line_levels, output now_ms, input ready);
    modport sink   (input valid, input line_levels, input now_ms, output ready);
endinterface

// Event channel
interface cbch_out_if;
    logic                            valid;
    logic                            ready;
    logic                            event_valid;
    logic [cbch_pkg::BTN_W-1:0]      button_index;
    logic [cbch_pkg::ACT_W-1:0]      action_kind;

    modport source (output valid, output event_valid, output button_index,
                    output action_kind, input ready);
    modport sink   (input valid, input event_valid, input button_index,
                    input action_kind, output ready);
endinterface

// Register write channel
interface cbch_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cbch_pkg::IDX_W-1:0]      index;
    logic [cbch_pkg::CFG_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/coded_button_click_hold_top.sv
// A sample transfer becomes its event item by way of the input register, then
// the result register.
// One sample per cycle while the event output is not stalled; the phase update is a single pass of
// compare-and-update logic between the input and result registers.
// Reset (synchronous, active low): phase idle, registers at 50/500/200 ms.
`default_nettype none

module coded_button_click_hold_top
    import cbch_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cbch_in_if.sink    i_in,
    cbch_cfg_if.sink   i_cfg,
    cbch_out_if.source o_out
);

    t_cfg              w_cfg;
    t_evt              w_evt;
    logic              w_adv;

    logic              r_in_valid;
    logic [LINE_W-1:0] r_line;
    logic [TIME_W-1:0] r_now;
    logic              r_out_valid;
    t_evt              r_evt;

    cbch_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // Stage advances when the result register is free or being drained
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_line <= i_in.line_levels;
            r_now  <= i_in.now_ms;
        end
    end

    cbch_fsm u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_line_levels (r_line),
        .i_now_ms      (r_now),
        .i_cfg         (w_cfg),
        .o_evt         (w_evt)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_evt <= w_evt;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_valid  = r_evt.event_valid;
    assign o_out.button_index = r_evt.button_index;
    assign o_out.action_kind  = r_evt.action_kind;

    // Empty input stage always takes a sample
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("input stage empty but not ready");

    // A sample advancing always lands in the result register
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced sample lost");

    // Non-events carry zero fields, events a defined kind
    a_evt_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
        (r_evt.event_valid ? (r_evt.action_kind != 2'd3)
                           : (r_evt.button_index == '0 && r_evt.action_kind == ACT_CLICK)))
        else $error("bad event fields");

endmodule

`default_nettype wire

### rtl/cbch_regs.sv
`default_nettype none

module cbch_regs
    import cbch_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cbch_cfg_if.sink    i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    // Writes are always taken
    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time      <= DEBOUNCE_RST;
            r_cfg.hold_threshold     <= HOLD_THR_RST;
            r_cfg.hold_repeat_period <= HOLD_REP_RST;
        end else if (w_wr) begin
            case (i_cfg.index)
                REG_DEBOUNCE: r_cfg.debounce_time      <= i_cfg.data;
                REG_HOLD_THR: r_cfg.hold_threshold     <= i_cfg.data;
                REG_HOLD_REP: r_cfg.hold_repeat_period <= i_cfg.data;
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/cbch_fsm.sv
`default_nettype none

module cbch_fsm
    import cbch_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic [LINE_W-1:0] i_line_levels,
    input  wire logic [TIME_W-1:0] i_now_ms,
    input  wire t_cfg              i_cfg,
    output t_evt                   o_evt
);

    t_phase              r_phase,     n_phase;
    logic [BTN_W-1:0]    r_pend_btn,  n_pend_btn;
    logic [BTN_W-1:0]    r_act_btn,   n_act_btn;
    logic [TIME_W-1:0]   r_start,     n_start;
    logic [TIME_W-1:0]   r_last_hold, n_last_hold;
    logic [TIME_W-1:0]   r_last_seen, n_last_seen;

    logic [LINE_W-1:0]   w_code;
    logic                w_raw_valid;
    logic [BTN_W-1:0]    w_raw;
    logic                w_is_active;
    logic [TIME_W-1:0]   w_since_start;
    logic [TIME_W-1:0]   w_since_seen;
    logic [TIME_W-1:0]   w_since_hold;
    logic                w_db_start;
    logic                w_db_seen;
    logic                w_hold_due;
    logic                w_rep_due;

    // Decode the active-low lines into a button number
    assign w_code      = ~i_line_levels;
    assign w_raw_valid = (w_code != '0);
    assign w_raw       = w_code - 3'd1;
    assign w_is_active = w_raw_valid && (w_raw == r_act_btn);

    // Elapsed times, modulo 2^32; seen time refreshes before the phase logic
    assign n_last_seen   = w_raw_valid ? i_now_ms : r_last_seen;
    assign w_since_start = i_now_ms - r_start;
    assign w_since_seen  = i_now_ms - n_last_seen;
    assign w_since_hold  = i_now_ms - r_last_hold;

    assign w_db_start = w_since_start >= {16'd0, i_cfg.debounce_time};
    assign w_db_seen  = w_since_seen  >= {16'd0, i_cfg.debounce_time};
    assign w_hold_due = w_since_start >= {16'd0, i_cfg.hold_threshold};
    assign w_rep_due  = w_since_hold  >= {16'd0, i_cfg.hold_repeat_period};

    // Next state and event
    always_comb begin
        n_phase     = r_phase;
        n_pend_btn  = r_pend_btn;
        n_act_btn   = r_act_btn;
        n_start     = r_start;
        n_last_hold = r_last_hold;
        o_evt       = '0;
        case (r_phase)
            PH_IDLE: begin
                if (w_raw_valid) begin
                    n_phase    = PH_DEBOUNCE;
                    n_pend_btn = w_raw;
                    n_start    = i_now_ms;
                end
            end
            PH_DEBOUNCE: begin
                if (w_db_start) begin
                    if (w_raw_valid && (w_raw == r_pend_btn)) begin
                        n_phase   = PH_PRESSED;
                        n_act_btn = r_pend_btn;
                    end else if (w_raw_valid) begin
                        n_pend_btn = w_raw;
                        n_start    = i_now_ms;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_PRESSED: begin
                if (!w_is_active) begin
                    if (w_db_seen) begin
                        o_evt   = '{1'b1, r_act_btn, ACT_CLICK};
                        n_phase = PH_IDLE;
                    end
                end else if (w_hold_due) begin
                    o_evt       = '{1'b1, r_act_btn, ACT_HOLD};
                    n_phase     = PH_HOLDING;
                    n_last_hold = i_now_ms;
                end
            end
            PH_HOLDING: begin
                if (!w_is_active) begin
                    if (w_db_seen) begin
                        o_evt   = '{1'b1, r_act_btn, ACT_RELEASE};
                        n_phase = PH_IDLE;
                    end
                end else if (w_rep_due) begin
                    o_evt       = '{1'b1, r_act_btn, ACT_HOLD};
                    n_last_hold = i_now_ms;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // State registers, advance once per transferred sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pend_btn  <= '0;
            r_act_btn   <= '0;
            r_start     <= '0;
            r_last_hold <= '0;
            r_last_seen <= '0;
        end else if (i_adv) begin
            r_phase     <= n_phase;
            r_pend_btn  <= n_pend_btn;
            r_act_btn   <= n_act_btn;
            r_start     <= n_start;
            r_last_hold <= n_last_hold;
            r_last_seen <= n_last_seen;
        end
    end

    // Click or release always returns to idle
    a_end_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && o_evt.event_valid &&
        (o_evt.action_kind == ACT_CLICK || o_evt.action_kind == ACT_RELEASE)
        |=> r_phase == PH_IDLE)
        else $error("click/release did not return to idle");

    // A hold event leaves the machine holding
    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && o_evt.event_valid && o_evt.action_kind == ACT_HOLD
        |=> r_phase == PH_HOLDING)
        else $error("hold event without holding phase");

    // Events come only from the pressed or holding phases
    a_evt_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt.event_valid |-> (r_phase == PH_PRESSED || r_phase == PH_HOLDING))
        else $error("event outside pressed/holding");

endmodule

`default_nettype wire

### tb/sv/tb_coded_button_click_hold_top.sv
`default_nettype none

module tb_coded_button_click_hold_top;
    import cbch_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS = 85;
    localparam int unsigned NUM_PHASES = 6;
    localparam int unsigned IDLE_PCT = 17;
    // Index past the last register; the block must ignore writes to it
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [LINE_W-1:0] LINES_IDLE = '1;

    typedef struct packed {
        logic [LINE_W-1:0] lines;
        logic [TIME_W-1:0] now;
    } t_sample;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cbch_in_if  smp ();
    cbch_cfg_if cfg_ch ();
    cbch_out_if evt ();

    coded_button_click_hold_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (smp),
        .i_cfg   (cfg_ch),
        .o_out   (evt)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stimulus and expected event stores
    t_sample sample_q[$];
    t_evt    event_q[$];

    // Predictor state, mirrors the block's registers
    t_cfg              m_regs;
    t_phase            m_phase;
    logic [BTN_W-1:0]  m_pend_btn;
    logic              m_pend_ok;
    logic [BTN_W-1:0]  m_act_btn;
    logic              m_act_ok;
    logic [TIME_W-1:0] m_start_ms;
    logic [TIME_W-1:0] m_hold_ms;
    logic [TIME_W-1:0] m_seen_ms;

    logic [TIME_W-1:0] t_ms;
    bit                steady_run = 1'b0;
    int unsigned       errors = 0;
    int unsigned       queued_n = 0;
    int unsigned       accepted_n = 0;
    int unsigned       writes_n = 0;
    int unsigned       clicks_n = 0;
    int unsigned       holds_n = 0;
    int unsigned       releases_n = 0;
    int unsigned       quiet_n = 0;
    int unsigned       cycles = 0;

    // Next-state and event prediction for one sample
    function automatic t_evt click_hold_step(input logic [LINE_W-1:0] lines,
                                             input logic [TIME_W-1:0] now);
        logic [LINE_W-1:0] code;
        logic              seen;
        logic [BTN_W-1:0]  btn;
        logic              on_active;
        logic [TIME_W-1:0] since_start;
        logic [TIME_W-1:0] since_seen;
        logic [TIME_W-1:0] since_hold;
        t_evt              ev;

        code = ~lines;
        seen = (code != '0);
        btn = BTN_W'(code - 3'd1);
        on_active = seen && m_act_ok && (btn == m_act_btn);
        ev = '0;
        if (seen)
            m_seen_ms = now;
        since_start = now - m_start_ms;
        since_seen = now - m_seen_ms;
        since_hold = now - m_hold_ms;

        case (m_phase)
            PH_IDLE: begin
                if (seen) begin
                    m_phase = PH_DEBOUNCE;
                    m_pend_btn = btn;
                    m_pend_ok = 1'b1;
                    m_start_ms = now;
                end
            end
            PH_DEBOUNCE: begin
                if (since_start >= TIME_W'(m_regs.debounce_time)) begin
                    if (seen && m_pend_ok && btn == m_pend_btn) begin
                        m_phase = PH_PRESSED;
                        m_act_btn = m_pend_btn;
                        m_act_ok = 1'b1;
                    end else if (seen) begin
                        // another button: restart debounce on it
                        m_pend_btn = btn;
                        m_pend_ok = 1'b1;
                        m_start_ms = now;
                    end else begin
                        m_phase = PH_IDLE;
                        m_pend_btn = '0;
                        m_pend_ok = 1'b0;
                    end
                end
            end
            default: begin
                // pressed or holding
                if (!on_active) begin
                    if (since_seen >= TIME_W'(m_regs.debounce_time)) begin
                        ev.event_valid = 1'b1;
                        ev.button_index = m_act_btn;
                        ev.action_kind = (m_phase == PH_PRESSED) ? ACT_CLICK : ACT_RELEASE;
                        m_phase = PH_IDLE;
                        m_act_btn = '0;
                        m_act_ok = 1'b0;
                        m_pend_btn = '0;
                        m_pend_ok = 1'b0;
                    end
                end else if (m_phase == PH_PRESSED) begin
                    if (since_start >= TIME_W'(m_regs.hold_threshold)) begin
                        m_phase = PH_HOLDING;
                        m_hold_ms = now;
                        ev.event_valid = 1'b1;
                        ev.button_index = m_act_btn;
                        ev.action_kind = ACT_HOLD;
                    end
                end else if (since_hold >= TIME_W'(m_regs.hold_repeat_period)) begin
                    m_hold_ms = now;
                    ev.event_valid = 1'b1;
                    ev.button_index = m_act_btn;
                    ev.action_kind = ACT_HOLD;
                end
            end
        endcase
        return ev;
    endfunction

    function automatic logic [LINE_W-1:0] btn_lines(input int unsigned btn);
        return ~LINE_W'(btn + 1);
    endfunction

    task automatic push_sample(input logic [LINE_W-1:0] lines, input logic [TIME_W-1:0] now);
        t_sample s;
        s.lines = lines;
        s.now = now;
        sample_q.push_back(s);
        queued_n++;
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || smp.valid || event_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Register writes back to back; predictor copy updates on each transfer
    task automatic write_regs(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] thr,
                              input logic [CFG_W-1:0] rep, input bit junk);
        logic [IDX_W-1:0] idxs[4];
        logic [CFG_W-1:0] vals[4];
        int               n;
        int               k;

        idxs[0] = REG_DEBOUNCE; vals[0] = db;
        idxs[1] = REG_HOLD_THR; vals[1] = thr;
        idxs[2] = REG_HOLD_REP; vals[2] = rep;
        idxs[3] = REG_UNUSED;   vals[3] = CFG_W'($urandom());
        n = junk ? 4 : 3;
        k = 0;
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idxs[0];
        cfg_ch.data <= vals[0];
        while (k < n) begin
            @(posedge i_clk);
            if (cfg_ch.ready) begin
                case (idxs[k])
                    REG_DEBOUNCE: m_regs.debounce_time = vals[k];
                    REG_HOLD_THR: m_regs.hold_threshold = vals[k];
                    REG_HOLD_REP: m_regs.hold_repeat_period = vals[k];
                    default: ;
                endcase
                writes_n++;
                k++;
                if (k < n) begin
                    cfg_ch.index <= idxs[k];
                    cfg_ch.data <= vals[k];
                end else begin
                    cfg_ch.valid <= 1'b0;
                end
            end
        end
    endtask

    // One press of a random button: settle, press (with rare glitches), release
    task automatic gen_press();
        int unsigned       db;
        int unsigned       thr;
        int unsigned       rep;
        int unsigned       step_ms;
        int unsigned       press_ms;
        int unsigned       rel_ms;
        int unsigned       el;
        logic [LINE_W-1:0] lv;

        db = m_regs.debounce_time;
        thr = m_regs.hold_threshold;
        rep = m_regs.hold_repeat_period;
        lv = btn_lines($urandom_range(6, 0));
        press_ms = $urandom_range(db + thr + 3 * rep + 20, 0);
        step_ms = $urandom_range((db + rep) / 6 + 2, 1);
        if (step_ms < press_ms / 30 + 1)
            step_ms = press_ms / 30 + 1;
        push_sample(LINES_IDLE, t_ms);
        el = 0;
        while (el <= press_ms) begin
            if ($urandom_range(99, 0) < 8)
                push_sample(LINE_W'($urandom_range(7, 0)), t_ms);
            else
                push_sample(lv, t_ms);
            t_ms += step_ms;
            el += step_ms;
        end
        rel_ms = db + $urandom_range(2 * step_ms, 1);
        if (step_ms < rel_ms / 8 + 1)
            step_ms = rel_ms / 8 + 1;
        el = 0;
        while (el < rel_ms) begin
            push_sample(LINES_IDLE, t_ms);
            t_ms += step_ms;
            el += step_ms;
        end
        push_sample(LINES_IDLE, t_ms);
        t_ms += $urandom_range(db + 50, 0);
    endtask

    // Random line levels, now and then a jump to an arbitrary time
    task automatic gen_noise();
        int unsigned n;
        int unsigned db;

        db = m_regs.debounce_time;
        n = $urandom_range(5, 1);
        repeat (n) begin
            if ($urandom_range(99, 0) < 10)
                t_ms = $urandom();
            else
                t_ms += $urandom_range(db + 5, 0);
            push_sample(LINE_W'($urandom_range(7, 0)), t_ms);
        end
    endtask

    // Sample driver
    always @(posedge i_clk) begin
        t_sample s;
        t_evt    ev;
        if (!i_rst_n) begin
            smp.valid <= 1'b0;
        end else begin
            if (smp.valid && smp.ready) begin
                ev = click_hold_step(smp.line_levels, smp.now_ms);
                event_q.push_back(ev);
                accepted_n++;
            end
            if (!smp.valid || smp.ready) begin
                if (sample_q.size() != 0 && (steady_run || $urandom_range(99, 0) >= IDLE_PCT)) begin
                    s = sample_q.pop_front();
                    smp.valid <= 1'b1;
                    smp.line_levels <= s.lines;
                    smp.now_ms <= s.now;
                end else begin
                    smp.valid <= 1'b0;
                end
            end
        end
    end

    // Event monitor and checker
    always @(posedge i_clk) begin
        t_evt want;
        if (!i_rst_n) begin
            evt.ready <= 1'b0;
        end else begin
            if (evt.valid && evt.ready) begin
                if (event_q.size() == 0) begin
                    $error("event transfer with no sample outstanding");
                    errors++;
                end else begin
                    want = event_q.pop_front();
                    if (evt.event_valid !== want.event_valid) begin
                        $error("event_valid: expected %0d, got %0d",
                               want.event_valid, evt.event_valid);
                        errors++;
                    end
                    if (evt.button_index !== want.button_index) begin
                        $error("button_index: expected %0d, got %0d",
                               want.button_index, evt.button_index);
                        errors++;
                    end
                    if (evt.action_kind !== want.action_kind) begin
                        $error("action_kind: expected %0d, got %0d",
                               want.action_kind, evt.action_kind);
                        errors++;
                    end
                    if (!want.event_valid)
                        quiet_n++;
                    else if (want.action_kind == ACT_CLICK)
                        clicks_n++;
                    else if (want.action_kind == ACT_HOLD)
                        holds_n++;
                    else
                        releases_n++;
                end
            end
            evt.ready <= steady_run || ($urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int unsigned base;

        smp.valid = 1'b0;
        smp.line_levels = LINES_IDLE;
        smp.now_ms = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_DEBOUNCE;
        cfg_ch.data = '0;
        evt.ready = 1'b0;

        m_regs.debounce_time = DEBOUNCE_RST;
        m_regs.hold_threshold = HOLD_THR_RST;
        m_regs.hold_repeat_period = HOLD_REP_RST;
        m_phase = PH_IDLE;
        m_pend_btn = '0;
        m_pend_ok = 1'b0;
        m_act_btn = '0;
        m_act_ok = 1'b0;
        m_start_ms = '0;
        m_hold_ms = '0;
        m_seen_ms = '0;
        t_ms = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset register values (50 / 500 / 200 ms)
        push_sample(LINES_IDLE, 32'd0);
        push_sample(btn_lines(0), 32'd100);        // debounce on button 0
        push_sample(btn_lines(1), 32'd160);        // other button during debounce
        push_sample(btn_lines(1), 32'd220);        // button 1 pressed
        push_sample(btn_lines(3), 32'd230);        // other button while pressed
        push_sample(LINES_IDLE, 32'd300);          // click
        push_sample(btn_lines(6), 32'd1000);
        push_sample(btn_lines(6), 32'd1060);
        push_sample(btn_lines(6), 32'd1500);       // hold start
        push_sample(btn_lines(6), 32'd1700);       // hold repeat
        push_sample(btn_lines(6), 32'd1800);
        push_sample(LINES_IDLE, 32'd1820);         // gone, not yet long enough
        push_sample(LINES_IDLE, 32'd1850);         // release after hold
        push_sample(btn_lines(5), 32'hFFFF_FFFF);  // press across time wrap
        push_sample(btn_lines(5), 32'h0000_0040);
        push_sample(btn_lines(4), 32'h0000_0048);
        push_sample(btn_lines(2), 32'h0000_0060);
        push_sample(LINES_IDLE, 32'h0000_0100);    // click on button 5
        wait_drained();

        // Directed, all times zero: everything fires at once
        write_regs('0, '0, '0, 1'b1);
        push_sample(btn_lines(2), 32'd10);
        push_sample(btn_lines(2), 32'd10);         // pressed
        push_sample(btn_lines(2), 32'd10);         // hold start
        push_sample(btn_lines(2), 32'd10);         // hold repeat
        push_sample(btn_lines(4), 32'd10);         // other button releases at once
        push_sample(LINES_IDLE, 32'd11);
        wait_drained();

        // Random phases, one register setting each
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: write_regs('1, '1, '1, 1'b0);
                1: write_regs(CFG_W'($urandom_range(100, 0)), CFG_W'($urandom_range(1000, 0)),
                              CFG_W'($urandom_range(400, 0)), 1'b1);
                2: begin
                    write_regs(DEBOUNCE_RST, HOLD_THR_RST, HOLD_REP_RST, 1'b0);
                    t_ms = 32'hFFFF_F000;
                    steady_run = 1'b1;
                end
                3: write_regs('0, CFG_W'($urandom_range(800, 0)),
                              CFG_W'($urandom_range(300, 0)), 1'b0);
                4: write_regs(CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()), 1'b1);
                default: write_regs(CFG_W'($urandom_range(80, 0)), '0, '0, 1'b0);
            endcase
            base = queued_n;
            while (queued_n - base < PHASE_ITEMS) begin
                if ($urandom_range(99, 0) < 85)
                    gen_press();
                else
                    gen_noise();
            end
            wait_drained();
            steady_run = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (event_q.size() != 0) begin
            $error("%0d expected events never arrived", event_q.size());
            errors++;
        end
        $display("Ran %0d samples over %0d register writes in eight register settings.",
                 accepted_n, writes_n);
        $display("Saw %0d clicks, %0d hold events, %0d releases, %0d quiet samples.",
                 clicks_n, holds_n, releases_n, quiet_n);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### coded_button_click_hold_top.f
rtl/cbch_pkg.sv
rtl/cbch_if.sv
rtl/cbch_regs.sv
rtl/cbch_fsm.sv
rtl/coded_button_click_hold_top.sv
tb/sv/tb_coded_button_click_hold_top.sv
